FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file of this block.
// Both macros expect signals named clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in next-cycle check");

`endif

FILE: rtl/core/nls_pkg.sv
// ----------------------------------------------------------------------------
// nls_pkg
// Types, constants and character class helpers for the numeric literal
// scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nls_pkg;

	localparam int MAX_LITERAL_LENGTH_DEF = 64;

	localparam int CHAR_W = 8;
	localparam int LINE_W = 24;
	localparam int POS_W = 32;
	localparam int TLEN_W = 7;

	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 1;

	localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ZERO  = 5'b00010,
		ST_INT   = 5'b00100,
		ST_POINT = 5'b01000,
		ST_FRAC  = 5'b10000
	} scan_state_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_TOO_LONG = 2'd1,
		ERR_NO_DIGIT = 2'd2
	} err_t;

	typedef struct packed {
		logic              token_done;
		logic [POS_W-1:0]  token_start;
		logic [POS_W-1:0]  token_end;
		logic [LINE_W-1:0] token_line;
		logic [TLEN_W-1:0] token_length;
		logic              has_fraction;
		logic              char_taken;
		err_t              error_code;
	} result_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_word_char(input logic [CHAR_W-1:0] c);
		return (c == CH_UNDERSCORE) ||
			((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
			((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
	endfunction

endpackage

FILE: rtl/core/nls_step.sv
// ----------------------------------------------------------------------------
// nls_step
// Next-state and result logic for one character: scanner transition, length
// check and token report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nls_step #(
	parameter int MAX_LITERAL_LENGTH = nls_pkg::MAX_LITERAL_LENGTH_DEF,
	localparam int LEN_W = $clog2(MAX_LITERAL_LENGTH + 1)
) (
	input  nls_pkg::scan_state_t            state,
	input  logic [nls_pkg::CHAR_W-1:0]      prev_char,
	input  logic [LEN_W-1:0]                lit_len,
	input  logic [nls_pkg::POS_W-1:0]       lit_start,
	input  logic [nls_pkg::CHAR_W-1:0]      char_code,
	input  logic [nls_pkg::LINE_W-1:0]      line_number,
	input  logic [nls_pkg::POS_W-1:0]       char_position,
	output nls_pkg::scan_state_t            state_nxt,
	output logic [LEN_W-1:0]                lit_len_nxt,
	output logic [nls_pkg::POS_W-1:0]       lit_start_nxt,
	output nls_pkg::result_t                result
);
	import nls_pkg::*;

	logic                    digit;
	logic                    full;
	logic [LEN_W+TLEN_W-1:0] len_ext;

	assign digit = is_digit(char_code);
	assign full = lit_len >= LEN_W'(MAX_LITERAL_LENGTH);
	assign len_ext = {{TLEN_W{1'b0}}, lit_len};

	always_comb begin
		state_nxt = state;
		lit_len_nxt = lit_len;
		lit_start_nxt = lit_start;
		result = '0;

		if (!is_word_char(prev_char)) begin
			// Each path below extends, closes or drops the literal, starts one from idle, or leaves the state as it is.
			case (state)
				ST_ZERO, ST_INT, ST_POINT, ST_FRAC: begin
					if ((state == ST_POINT) && !digit) begin
						result.error_code = ERR_NO_DIGIT;
						state_nxt = ST_IDLE;
					end else if (digit && (state == ST_ZERO)) begin
						state_nxt = ST_ZERO;
					end else if (digit || ((char_code == CH_POINT) &&
						(state == ST_ZERO || state == ST_INT))) begin
						if (full) begin
							result.error_code = ERR_TOO_LONG;
							state_nxt = ST_IDLE;
						end else begin
							lit_len_nxt = lit_len + LEN_W'(1);
							result.char_taken = 1'b1;
							if (!digit) begin
								state_nxt = ST_POINT;
							end else if (state == ST_INT) begin
								state_nxt = ST_INT;
							end else begin
								state_nxt = ST_FRAC;
							end
						end
					end else begin
						result.token_done = 1'b1;
						result.token_start = lit_start;
						result.token_end = char_position - POS_W'(1);
						result.token_line = line_number;
						result.token_length = len_ext[TLEN_W-1:0];
						result.has_fraction = (state == ST_FRAC);
						state_nxt = ST_IDLE;
					end
				end
				default: begin
					state_nxt = ST_IDLE;
					lit_len_nxt = '0;
					if (digit) begin
						lit_start_nxt = char_position;
						lit_len_nxt = LEN_W'(1);
						result.char_taken = 1'b1;
						state_nxt = (char_code == CH_ZERO) ? ST_ZERO : ST_INT;
					end
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/numeric_literal_scanner.sv
// A word accepted is held in the input register, then moved to the result register, which drives the output.
// Throughput: one character word per cycle while the output is not stalled; the
// scanner state is updated as a word moves from the input register to the result
// register, so back-to-back words see each other's effect with no bubble.
// Reset (arst_n low) empties both registers and returns the scanner to idle
// with the previous character, literal length and start position cleared.
// ----------------------------------------------------------------------------
// numeric_literal_scanner
// Recognises decimal integer and fraction literals in a character stream and
// reports each completed literal by position, line, length and kind, flagging errors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module numeric_literal_scanner #(
	parameter int MAX_LITERAL_LENGTH = nls_pkg::MAX_LITERAL_LENGTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// char_code[7:0], line_number[31:8], char_position[63:32]
	input  logic [nls_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// token_start[31:0], token_end[63:32], token_line[87:64],
	// token_length[94:88], has_fraction[95], char_taken[96],
	// error_code[98:97], zero padding[103:99]
	output logic [nls_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// token_done[0]
	output logic [nls_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
	import nls_pkg::*;

	localparam int LEN_W = $clog2(MAX_LITERAL_LENGTH + 1);

	logic                 valid_s1;
	logic [CHAR_W-1:0]    char_s1;
	logic [LINE_W-1:0]    line_s1;
	logic [POS_W-1:0]     pos_s1;
	logic                 valid_s2;
	result_t              result_s2;

	scan_state_t          state_q;
	logic [CHAR_W-1:0]    prev_char_q;
	logic [LEN_W-1:0]     lit_len_q;
	logic [POS_W-1:0]     lit_start_q;

	scan_state_t          state_nxt;
	logic [LEN_W-1:0]     lit_len_nxt;
	logic [POS_W-1:0]     lit_start_nxt;
	result_t              result;

	logic                 advance;
	logic                 accept;

	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept = s_axis_tvalid && s_axis_tready;

	nls_step #(
		.MAX_LITERAL_LENGTH(MAX_LITERAL_LENGTH)
	) u_step (
		.state         (state_q),
		.prev_char     (prev_char_q),
		.lit_len       (lit_len_q),
		.lit_start     (lit_start_q),
		.char_code     (char_s1),
		.line_number   (line_s1),
		.char_position (pos_s1),
		.state_nxt     (state_nxt),
		.lit_len_nxt   (lit_len_nxt),
		.lit_start_nxt (lit_start_nxt),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q <= ST_IDLE;
			prev_char_q <= '0;
			lit_len_q <= '0;
			lit_start_q <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q <= state_nxt;
				prev_char_q <= char_s1;
				lit_len_q <= lit_len_nxt;
				lit_start_q <= lit_start_nxt;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= s_axis_tdata[CHAR_W-1:0];
			line_s1 <= s_axis_tdata[CHAR_W+LINE_W-1:CHAR_W];
			pos_s1 <= s_axis_tdata[CHAR_W+LINE_W+POS_W-1:CHAR_W+LINE_W];
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser = OUT_USER_W'(result_s2.token_done);
	assign m_axis_tdata = {
		5'b0,
		result_s2.error_code,
		result_s2.char_taken,
		result_s2.has_fraction,
		result_s2.token_length,
		result_s2.token_line,
		result_s2.token_end,
		result_s2.token_start
	};

endmodule

FILE: rtl/core/nls_checker.sv
// ----------------------------------------------------------------------------
// nls_checker
// Port-level checks on the numeric literal scanner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nls_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [nls_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [nls_pkg::OUT_USER_W-1:0] m_axis_tuser
);
	import nls_pkg::*;

	logic out_stall;

	assign out_stall = m_axis_tvalid && !m_axis_tready;

	// A stalled result word must neither vanish nor change.
	`ASSERT_NEXT(a_out_hold_valid, out_stall, m_axis_tvalid)
	`ASSERT_NEXT(a_out_hold_data, out_stall, $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// Token fields are only populated when a literal is reported.
	`ASSERT_SAME(a_idle_fields_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[95:0] == '0)

	// A report, an appended character and an error exclude one another.
	`ASSERT_SAME(a_exclusive_outcome, m_axis_tvalid, $countones({m_axis_tuser[0], m_axis_tdata[96], m_axis_tdata[98:97] != ERR_NONE}) <= 1)

	// The input side only waits while a result word is held back.
	`ASSERT_SAME(a_ready_when_free, !out_stall, s_axis_tready)

endmodule

bind numeric_literal_scanner nls_checker u_nls_checker (.*);
